[src/vna_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vna_pkg
// Shared types and constants of the vertex normal accumulator.
// ----------------------------------------------------------------------------
package vna_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int IDX_W        = 10;
  localparam int POS_W        = 16;
  localparam int SIDE_W       = 17;
  localparam int PROD_W       = 34;
  localparam int CROSS_W      = 35;
  localparam int ACC_W        = 48;
  localparam int MAG_W        = 24;
  localparam int SQ_W         = 48;
  localparam int SUM_W        = 50;
  localparam int ROOT_W       = 25;
  localparam int SREM_W       = 27;
  localparam int DREM_W       = 25;
  localparam int QUO_W        = 15;
  localparam int DIVN_W       = 39;
  localparam int NRM_W        = 16;
  localparam int NORM_ONE     = 16384;
  localparam int STEP_W       = 6;

  localparam logic [STEP_W-1:0] TRI_RD_LAST  = STEP_W'(3);
  localparam logic [STEP_W-1:0] TRI_MUL_LAST = STEP_W'(6);
  localparam logic [STEP_W-1:0] TRI_ACC_LAST = STEP_W'(5);
  localparam logic [STEP_W-1:0] SQ_LAST      = STEP_W'(3);
  localparam logic [STEP_W-1:0] SQRT_LAST    = STEP_W'(ROOT_W - 1);
  localparam logic [STEP_W-1:0] DIV_LAST     = STEP_W'(QUO_W);
  localparam logic [1:0]        COMP_LAST    = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_TRI  = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LOAD,
    S_TRI_RD,
    S_TRI_SIDE,
    S_TRI_MUL,
    S_TRI_ACC,
    S_RD_ACC,
    S_RD_MAG,
    S_RD_SHIFT,
    S_RD_SQ,
    S_RD_SQRT,
    S_RD_DIV,
    S_RD_OUT
  } ctl_state_t;

  typedef struct packed {
    logic              capture;
    logic              load_wr;
    logic              clr_wr;
    logic [ADDR_W-1:0] clr_addr;
    logic              pos_rd;
    logic              pos_cap;
    logic              side_en;
    logic              mul_en;
    logic              cross_en;
    logic              acc_rd_tri;
    logic              acc_rd_vtx;
    logic              acc_wr;
    logic              mag_en;
    logic              shift_en;
    logic              sq_en;
    logic              sqrt_en;
    logic              div_init;
    logic              div_en;
    logic              out_load;
    logic [STEP_W-1:0] step;
    logic [1:0]        comp;
  } vna_cmd_t;

  typedef struct packed {
    op_t  op;
    logic in_ok;
    logic zero;
    logic big;
    logic out_free;
  } vna_status_t;

endpackage

[src/vna_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vna_ctrl
// Sequencer: clearing pass, load, add-triangle and read sequences.
// ----------------------------------------------------------------------------
module vna_ctrl
  import vna_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  vna_status_t st,
  output vna_cmd_t    cmd
);

  ctl_state_t        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [1:0]        comp_r, comp_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      step_r  <= '0;
      comp_r  <= '0;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      comp_r  <= comp_nxt;
      clr_r   <= clr_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_r == ADDR_W'(MAX_VERTICES - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && st.in_ok) begin
          unique case (st.op)
            OP_LOAD: state_nxt = S_LOAD;
            OP_TRI:  state_nxt = S_TRI_RD;
            OP_READ: state_nxt = S_RD_ACC;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_LOAD:     state_nxt = S_IDLE;
      S_TRI_RD:   if (step_r == TRI_RD_LAST) state_nxt = S_TRI_SIDE;
      S_TRI_SIDE: state_nxt = S_TRI_MUL;
      S_TRI_MUL:  if (step_r == TRI_MUL_LAST) state_nxt = S_TRI_ACC;
      S_TRI_ACC:  if (step_r == TRI_ACC_LAST) state_nxt = S_IDLE;
      S_RD_ACC:   state_nxt = S_RD_MAG;
      S_RD_MAG:   state_nxt = S_RD_SHIFT;
      S_RD_SHIFT: begin
        if (st.zero) state_nxt = S_RD_OUT;
        else if (!st.big) state_nxt = S_RD_SQ;
      end
      S_RD_SQ:    if (step_r == SQ_LAST) state_nxt = S_RD_SQRT;
      S_RD_SQRT:  if (step_r == SQRT_LAST) state_nxt = S_RD_DIV;
      S_RD_DIV:   if (step_r == DIV_LAST && comp_r == COMP_LAST) state_nxt = S_RD_OUT;
      S_RD_OUT:   if (st.out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // step and component counters
  always_comb begin
    clr_nxt  = clr_r;
    comp_nxt = comp_r;
    step_nxt = step_r + STEP_W'(1);
    if (state_r == S_CLEAR) clr_nxt = clr_r + ADDR_W'(1);
    if (state_nxt != state_r) begin
      step_nxt = '0;
      comp_nxt = '0;
    end else if (state_r == S_RD_DIV && step_r == DIV_LAST) begin
      step_nxt = '0;
      comp_nxt = comp_r + 2'd1;
    end
  end

  // outputs
  always_comb begin
    cmd          = '0;
    cmd.step     = step_r;
    cmd.comp     = comp_r;
    cmd.clr_addr = clr_r;
    in_stall     = 1'b1;
    unique case (state_r)
      S_CLEAR:    cmd.clr_wr = 1'b1;
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      S_LOAD:     cmd.load_wr = 1'b1;
      S_TRI_RD: begin
        cmd.pos_rd  = (step_r < TRI_RD_LAST);
        cmd.pos_cap = (step_r != '0);
      end
      S_TRI_SIDE: cmd.side_en = 1'b1;
      S_TRI_MUL: begin
        cmd.mul_en   = (step_r < TRI_MUL_LAST);
        cmd.cross_en = (step_r != '0);
      end
      S_TRI_ACC: begin
        cmd.acc_rd_tri = !step_r[0];
        cmd.acc_wr     = step_r[0];
      end
      S_RD_ACC:   cmd.acc_rd_vtx = 1'b1;
      S_RD_MAG:   cmd.mag_en = 1'b1;
      S_RD_SHIFT: cmd.shift_en = !st.zero && st.big;
      S_RD_SQ:    cmd.sq_en = 1'b1;
      S_RD_SQRT:  cmd.sqrt_en = 1'b1;
      S_RD_DIV: begin
        cmd.div_init = (step_r == '0);
        cmd.div_en   = (step_r != '0);
      end
      S_RD_OUT:   cmd.out_load = st.out_free;
      default:    in_stall = 1'b1;
    endcase
  end

endmodule

[src/vna_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vna_dp
// Position and accumulator memories, cross product, normalization units.
// ----------------------------------------------------------------------------
module vna_dp
  import vna_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [1:0]              in_operation,
  input  logic [IDX_W-1:0]        in_vertex_index,
  input  logic signed [POS_W-1:0] in_pos_x,
  input  logic signed [POS_W-1:0] in_pos_y,
  input  logic signed [POS_W-1:0] in_pos_z,
  input  logic [IDX_W-1:0]        in_corner_a,
  input  logic [IDX_W-1:0]        in_corner_b,
  input  logic [IDX_W-1:0]        in_corner_c,
  input  vna_cmd_t                cmd,
  output vna_status_t             st,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [IDX_W-1:0]        out_index,
  output logic signed [NRM_W-1:0] out_normal_x,
  output logic signed [NRM_W-1:0] out_normal_y,
  output logic signed [NRM_W-1:0] out_normal_z,
  output logic                    out_zero_length
);

  // memories
  logic [3*POS_W-1:0] pos_mem [MAX_VERTICES];
  logic [3*ACC_W-1:0] acc_mem [MAX_VERTICES];
  logic [3*POS_W-1:0] pos_q_r;
  logic [3*ACC_W-1:0] acc_q_r;

  // captured request
  logic [IDX_W-1:0]   idx_r;
  logic [3*POS_W-1:0] pin_r;
  logic [IDX_W-1:0]   ca_r, cb_r, cc_r;

  // add-triangle datapath
  logic [3*POS_W-1:0]        p1_r, p2_r, p3_r;
  logic signed [SIDE_W-1:0]  s1_r [3];
  logic signed [SIDE_W-1:0]  s2_r [3];
  logic signed [SIDE_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [CROSS_W-1:0] n_r [3];

  // read datapath
  logic [2:0]        sign_r;
  logic [ACC_W-1:0]  mag_r [3];
  logic              zero_r;
  logic [MAG_W-1:0]  sq_op;
  logic [SQ_W-1:0]   sq_r;
  logic [SUM_W-1:0]  sum_r;
  logic [ROOT_W-1:0] root_r;
  logic [SREM_W-1:0] srem_r;
  logic [DREM_W-1:0] drem_r;
  logic [QUO_W-1:0]  dq_r;
  logic [NRM_W-1:0]  nrm_r [3];

  logic [ADDR_W-1:0] idx_addr, tri_addr;
  logic [1:0]        corner_sel;
  logic              acc_we, acc_re;
  logic [ADDR_W-1:0] acc_waddr, acc_raddr;
  logic [3*ACC_W-1:0] acc_wdata;

  logic [SREM_W+1:0] st_t, st_trial;
  logic              st_ge;
  logic [DIVN_W-1:0] div_n;
  logic [DREM_W:0]   dv_t;
  logic              dv_ge;
  logic [QUO_W-1:0]  dq_nxt;
  logic [MAG_W-1:0]  div_m;
  logic [NRM_W-1:0]  field;
  logic [2:0]        jstep;

  logic              out_valid_r;
  logic [IDX_W-1:0]  out_index_r;
  logic [NRM_W-1:0]  out_nx_r, out_ny_r, out_nz_r;
  logic              out_zero_r;

  function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                               input logic signed [CROSS_W-1:0] b);
    logic signed [ACC_W:0] s;
    s = $signed({a[ACC_W-1], a}) + (ACC_W+1)'(b);
    if (s[ACC_W] != s[ACC_W-1]) begin
      sat_add = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      sat_add = s[ACC_W-1:0];
    end
  endfunction

  // status
  always_comb begin
    st.op    = op_t'(in_operation);
    st.in_ok = 1'b0;
    unique case (op_t'(in_operation))
      OP_LOAD, OP_READ: st.in_ok = (32'(in_vertex_index) < MAX_VERTICES);
      OP_TRI: st.in_ok = (32'(in_corner_a) < MAX_VERTICES) &&
                         (32'(in_corner_b) < MAX_VERTICES) &&
                         (32'(in_corner_c) < MAX_VERTICES);
      default: st.in_ok = 1'b0;
    endcase
    st.zero     = zero_r;
    st.big      = (|mag_r[0][ACC_W-1:MAG_W]) || (|mag_r[1][ACC_W-1:MAG_W]) ||
                  (|mag_r[2][ACC_W-1:MAG_W]);
    st.out_free = !out_valid_r || !out_stall;
  end

  // address and write selection
  always_comb begin
    corner_sel = cmd.pos_rd ? cmd.step[1:0] : cmd.step[2:1];
    idx_addr   = ADDR_W'(idx_r);
    case (corner_sel)
      2'd0:    tri_addr = ADDR_W'(ca_r);
      2'd1:    tri_addr = ADDR_W'(cb_r);
      default: tri_addr = ADDR_W'(cc_r);
    endcase
    acc_we    = cmd.clr_wr || cmd.load_wr || cmd.acc_wr;
    acc_waddr = tri_addr;
    acc_wdata = '0;
    if (cmd.clr_wr) begin
      acc_waddr = cmd.clr_addr;
    end else if (cmd.load_wr) begin
      acc_waddr = idx_addr;
    end else begin
      acc_wdata = {sat_add(acc_q_r[3*ACC_W-1:2*ACC_W], n_r[0]),
                   sat_add(acc_q_r[2*ACC_W-1:ACC_W],   n_r[1]),
                   sat_add(acc_q_r[ACC_W-1:0],         n_r[2])};
    end
    acc_re    = cmd.acc_rd_tri || cmd.acc_rd_vtx;
    acc_raddr = cmd.acc_rd_vtx ? idx_addr : tri_addr;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_wr) pos_mem[idx_addr] <= pin_r;
    if (cmd.pos_rd) pos_q_r <= pos_mem[tri_addr];
    if (acc_we) acc_mem[acc_waddr] <= acc_wdata;
    if (acc_re) acc_q_r <= acc_mem[acc_raddr];
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      idx_r <= in_vertex_index;
      pin_r <= {in_pos_x, in_pos_y, in_pos_z};
      ca_r  <= in_corner_a;
      cb_r  <= in_corner_b;
      cc_r  <= in_corner_c;
    end
  end

  // cross product: one shared multiplier, six products
  always_comb begin
    jstep = cmd.step[2:0] - 3'd1;
    case (cmd.step[2:0])
      3'd0: begin mul_a = s1_r[1]; mul_b = s2_r[2]; end
      3'd1: begin mul_a = s1_r[2]; mul_b = s2_r[1]; end
      3'd2: begin mul_a = s1_r[2]; mul_b = s2_r[0]; end
      3'd3: begin mul_a = s1_r[0]; mul_b = s2_r[2]; end
      3'd4: begin mul_a = s1_r[0]; mul_b = s2_r[1]; end
      default: begin mul_a = s1_r[1]; mul_b = s2_r[0]; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.pos_cap) begin
      case (cmd.step[1:0])
        2'd1:    p1_r <= pos_q_r;
        2'd2:    p2_r <= pos_q_r;
        default: p3_r <= pos_q_r;
      endcase
    end
    if (cmd.side_en) begin
      for (int k = 0; k < 3; k++) begin
        s1_r[k] <= SIDE_W'($signed(p1_r[(2-k)*POS_W +: POS_W])) -
                   SIDE_W'($signed(p3_r[(2-k)*POS_W +: POS_W]));
        s2_r[k] <= SIDE_W'($signed(p1_r[(2-k)*POS_W +: POS_W])) -
                   SIDE_W'($signed(p2_r[(2-k)*POS_W +: POS_W]));
      end
    end
    if (cmd.mul_en) prod_r <= mul_a * mul_b;
    if (cmd.cross_en) begin
      case (jstep[2:1])
        2'd0: n_r[0] <= jstep[0] ? n_r[0] - CROSS_W'(prod_r) : CROSS_W'(prod_r);
        2'd1: n_r[1] <= jstep[0] ? n_r[1] - CROSS_W'(prod_r) : CROSS_W'(prod_r);
        default: n_r[2] <= jstep[0] ? n_r[2] - CROSS_W'(prod_r) : CROSS_W'(prod_r);
      endcase
    end
  end

  // normalization: shift search, sum of squares, square root, division
  always_comb begin
    case (cmd.step[1:0])
      2'd0:    sq_op = mag_r[0][MAG_W-1:0];
      2'd1:    sq_op = mag_r[1][MAG_W-1:0];
      default: sq_op = mag_r[2][MAG_W-1:0];
    endcase
    st_t     = {srem_r, sum_r[SUM_W-1:SUM_W-2]};
    st_trial = (SREM_W+2)'({root_r, 2'b01});
    st_ge    = (st_t >= st_trial);
    case (cmd.comp)
      2'd0:    div_m = mag_r[0][MAG_W-1:0];
      2'd1:    div_m = mag_r[1][MAG_W-1:0];
      default: div_m = mag_r[2][MAG_W-1:0];
    endcase
    div_n  = DIVN_W'({div_m, 14'd0}) + DIVN_W'(root_r >> 1);
    dv_t   = {drem_r, dq_r[QUO_W-1]};
    dv_ge  = (dv_t >= {1'b0, root_r});
    dq_nxt = {dq_r[QUO_W-2:0], dv_ge};
    field  = (dq_nxt > QUO_W'(NORM_ONE)) ? NRM_W'(NORM_ONE) : NRM_W'(dq_nxt);
    if (sign_r[2 - cmd.comp]) field = ~field + NRM_W'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.mag_en) begin
      for (int k = 0; k < 3; k++) begin
        sign_r[2-k] <= acc_q_r[(2-k)*ACC_W + ACC_W - 1];
        mag_r[k]    <= acc_q_r[(2-k)*ACC_W + ACC_W - 1] ?
                       (~acc_q_r[(2-k)*ACC_W +: ACC_W] + ACC_W'(1)) :
                       acc_q_r[(2-k)*ACC_W +: ACC_W];
      end
      zero_r <= (acc_q_r == '0);
    end
    if (cmd.shift_en) begin
      for (int k = 0; k < 3; k++) mag_r[k] <= mag_r[k] >> 1;
    end
    if (cmd.sq_en) begin
      sq_r <= sq_op * sq_op;
      if (cmd.step == '0) begin
        srem_r <= '0;
        root_r <= '0;
      end else if (cmd.step == STEP_W'(1)) begin
        sum_r <= SUM_W'(sq_r);
      end else begin
        sum_r <= sum_r + SUM_W'(sq_r);
      end
    end
    if (cmd.sqrt_en) begin
      sum_r  <= {sum_r[SUM_W-3:0], 2'b00};
      srem_r <= st_ge ? SREM_W'(st_t - st_trial) : SREM_W'(st_t);
      root_r <= {root_r[ROOT_W-2:0], st_ge};
    end
    if (cmd.div_init) begin
      drem_r <= DREM_W'(div_n[DIVN_W-1:QUO_W]);
      dq_r   <= div_n[QUO_W-1:0];
    end
    if (cmd.div_en) begin
      drem_r <= dv_ge ? DREM_W'(dv_t - {1'b0, root_r}) : DREM_W'(dv_t);
      dq_r   <= dq_nxt;
      if (cmd.step == DIV_LAST) begin
        case (cmd.comp)
          2'd0:    nrm_r[0] <= field;
          2'd1:    nrm_r[1] <= field;
          default: nrm_r[2] <= field;
        endcase
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_index_r <= idx_r;
      out_nx_r    <= zero_r ? '0 : nrm_r[0];
      out_ny_r    <= zero_r ? '0 : nrm_r[1];
      out_nz_r    <= zero_r ? '0 : nrm_r[2];
      out_zero_r  <= zero_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_index       = out_index_r;
  assign out_normal_x    = $signed(out_nx_r);
  assign out_normal_y    = $signed(out_ny_r);
  assign out_normal_z    = $signed(out_nz_r);
  assign out_zero_length = out_zero_r;

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("result register overwritten while held");

  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_zero_r) |-> (out_nx_r == '0 && out_ny_r == '0 && out_nz_r == '0))
    else $error("zero-length result with nonzero components");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($signed(out_nx_r) <= 16'sd16384 && $signed(out_nx_r) >= -16'sd16384 &&
                     $signed(out_ny_r) <= 16'sd16384 && $signed(out_ny_r) >= -16'sd16384 &&
                     $signed(out_nz_r) <= 16'sd16384 && $signed(out_nz_r) >= -16'sd16384))
    else $error("normal component beyond unit range");

  a_rmw_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc_wr |-> $past(cmd.acc_rd_tri))
    else $error("accumulator write without preceding read");

endmodule

[src/vertex_normal_accumulator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_normal_accumulator
// Per-vertex smoothed normals: load positions, add triangles, read unit normals.
// ----------------------------------------------------------------------------
//   channel | handshake             | payload
//   in      | in_valid / in_stall   | operation, vertex index, position, corners
//   out     | out_valid / out_stall | vertex index, Q1.14 normal, zero flag
//
// After reset the accumulator memory is cleared, one entry a cycle; requests
// are held off until then. An add-triangle makes three position reads, six
// products on one multiplier and three read-modify-writes. The length of a
// read is set by the bit-serial shift search (0..24), the 25-step square root
// and three divisions, one per component; a zero accumulator skips them all.
// A finished read waits in the result register while out_stall is high; the
// next request is still accepted.
module vertex_normal_accumulator
  import vna_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_operation,
  input  logic [IDX_W-1:0]        in_vertex_index,
  input  logic signed [POS_W-1:0] in_pos_x,
  input  logic signed [POS_W-1:0] in_pos_y,
  input  logic signed [POS_W-1:0] in_pos_z,
  input  logic [IDX_W-1:0]        in_corner_a,
  input  logic [IDX_W-1:0]        in_corner_b,
  input  logic [IDX_W-1:0]        in_corner_c,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [IDX_W-1:0]        out_index,
  output logic signed [NRM_W-1:0] out_normal_x,
  output logic signed [NRM_W-1:0] out_normal_y,
  output logic signed [NRM_W-1:0] out_normal_z,
  output logic                    out_zero_length
);

  vna_cmd_t    cmd;
  vna_status_t st;

  vna_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  vna_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_operation    (in_operation),
    .in_vertex_index (in_vertex_index),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_pos_z        (in_pos_z),
    .in_corner_a     (in_corner_a),
    .in_corner_b     (in_corner_b),
    .in_corner_c     (in_corner_c),
    .cmd             (cmd),
    .st              (st),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_index       (out_index),
    .out_normal_x    (out_normal_x),
    .out_normal_y    (out_normal_y),
    .out_normal_z    (out_normal_z),
    .out_zero_length (out_zero_length)
  );

endmodule
